[sv/ccsu_pkg.sv]
`default_nettype none
package ccsu_pkg;

  // configuration register indexes
  localparam logic [2:0] RegKey01 = 3'd0;
  localparam logic [2:0] RegKey23 = 3'd1;
  localparam logic [2:0] RegKey45 = 3'd2;
  localparam logic [2:0] RegKey67 = 3'd3;
  localparam logic [2:0] RegNonce = 3'd4;

  // sigma words of the block layout
  localparam logic [31:0] Sigma0 = 32'h6170_7865;
  localparam logic [31:0] Sigma1 = 32'h3320_646e;
  localparam logic [31:0] Sigma2 = 32'h7962_2d32;
  localparam logic [31:0] Sigma3 = 32'h6b20_6574;

  localparam logic [2:0] FullWordBytes = 3'd4;

  typedef logic [15:0][31:0] block_t;

  // key and nonce as held by the register file
  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce;
  } cfg_t;

  // one classified word on its way from front to back
  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        build;
    logic [31:0] ctr;
    logic [3:0]  pos;
  } entry_t;

  // block core status
  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // one quarter round on words a, b, c, d
  function automatic logic [3:0][31:0] qround(input logic [31:0] a_in,
                                              input logic [31:0] b_in,
                                              input logic [31:0] c_in,
                                              input logic [31:0] d_in);
    logic [31:0] a, b, c, d;
    a = a_in; b = b_in; c = c_in; d = d_in;
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    qround = {d, c, b, a};
  endfunction

  // input block from key, nonce and counter
  function automatic block_t make_init(input cfg_t cfg, input logic [31:0] ctr);
    block_t w;
    w[0] = Sigma0;
    w[1] = Sigma1;
    w[2] = Sigma2;
    w[3] = Sigma3;
    for (int i = 0; i < 4; i++) begin
      w[4 + 2 * i] = cfg.key[i][31:0];
      w[5 + 2 * i] = cfg.key[i][63:32];
    end
    w[12] = ctr;
    w[13] = 32'd0;
    w[14] = cfg.nonce[31:0];
    w[15] = cfg.nonce[63:32];
    make_init = w;
  endfunction

endpackage
`default_nettype wire

[sv/ccsu_ifs.sv]
`default_nettype none
interface ccsu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        message_start;
  modport source(output valid, output data_word, output valid_bytes,
                 output message_start, input ready);
  modport sink(input valid, input data_word, input valid_bytes,
               input message_start, output ready);
endinterface

interface ccsu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word;
  logic [2:0]  result_bytes;
  modport source(output valid, output result_word, output result_bytes, input ready);
  modport sink(input valid, input result_word, input result_bytes, output ready);
endinterface

interface ccsu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/ccsu_front.sv]
`default_nettype none
module ccsu_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  ccsu_in_if.sink              in_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output ccsu_pkg::entry_t     entry_o
);

  logic [3:0]  pos_q, pos_d;
  logic [31:0] ctr_q, ctr_d;
  logic [3:0]  pos_cur;
  logic [31:0] ctr_cur;
  logic        build;

  assign in_i.ready = ~full_i;
  assign push_o     = in_i.valid & ~full_i;

  // restart on message start, new block at word zero
  always_comb begin
    pos_cur = in_i.message_start ? 4'd0 : pos_q;
    ctr_cur = in_i.message_start ? 32'd0 : ctr_q;
    build   = (pos_cur == 4'd0);
    pos_d   = pos_cur + 4'd1;
    ctr_d   = build ? ctr_cur + 32'd1 : ctr_cur;
  end

  // classified entry, byte count saturated at a full word
  always_comb begin
    entry_o.data   = in_i.data_word;
    entry_o.nbytes = (in_i.valid_bytes > ccsu_pkg::FullWordBytes) ?
                     ccsu_pkg::FullWordBytes : in_i.valid_bytes;
    entry_o.build  = build;
    entry_o.ctr    = ctr_cur;
    entry_o.pos    = pos_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
      ctr_q <= 32'd0;
    end else if (push_o) begin
      pos_q <= pos_d;
      ctr_q <= ctr_d;
    end
  end

endmodule
`default_nettype wire

[sv/ccsu_queue.sv]
`default_nettype none
module ccsu_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ccsu_pkg::entry_t  entry_i,
  input  wire logic              pop_i,
  output logic                   full_o,
  output logic                   valid_o,
  output ccsu_pkg::entry_t       head_o
);

  ccsu_pkg::entry_t [1:0] slot_q;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = slot_q[rd_q];

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule
`default_nettype wire

[sv/ccsu_core.sv]
`default_nettype none
module ccsu_core #(
  parameter int ROUND_COUNT = 20
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ccsu_pkg::cfg_t    cfg_i,
  input  wire logic              start_i,
  input  wire logic [31:0]       ctr_i,
  output ccsu_pkg::core_stat_t   stat_o,
  output ccsu_pkg::block_t       ks_o
);

  // rounds go in column/diagonal pairs
  localparam int RoundsEff = ((ROUND_COUNT + 1) / 2) * 2;
  localparam int RndW      = $clog2(RoundsEff);

  localparam logic [1:0] CIdle  = 2'd0;
  localparam logic [1:0] CRound = 2'd1;
  localparam logic [1:0] CFinal = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [RndW-1:0]   rnd_q, rnd_d;
  logic [31:0]       ctr_q;
  ccsu_pkg::block_t  w_q, w_d, rnd_out, init_words;
  logic [3:0][31:0]  q0, q1, q2, q3;

  assign init_words = ccsu_pkg::make_init(cfg_i, ctr_q);

  // one round: four quarter rounds side by side
  always_comb begin
    if (!rnd_q[0]) begin
      q0 = ccsu_pkg::qround(w_q[0], w_q[4], w_q[8],  w_q[12]);
      q1 = ccsu_pkg::qround(w_q[1], w_q[5], w_q[9],  w_q[13]);
      q2 = ccsu_pkg::qround(w_q[2], w_q[6], w_q[10], w_q[14]);
      q3 = ccsu_pkg::qround(w_q[3], w_q[7], w_q[11], w_q[15]);
      rnd_out[0] = q0[0]; rnd_out[4] = q0[1]; rnd_out[8]  = q0[2]; rnd_out[12] = q0[3];
      rnd_out[1] = q1[0]; rnd_out[5] = q1[1]; rnd_out[9]  = q1[2]; rnd_out[13] = q1[3];
      rnd_out[2] = q2[0]; rnd_out[6] = q2[1]; rnd_out[10] = q2[2]; rnd_out[14] = q2[3];
      rnd_out[3] = q3[0]; rnd_out[7] = q3[1]; rnd_out[11] = q3[2]; rnd_out[15] = q3[3];
    end else begin
      q0 = ccsu_pkg::qround(w_q[0], w_q[5], w_q[10], w_q[15]);
      q1 = ccsu_pkg::qround(w_q[1], w_q[6], w_q[11], w_q[12]);
      q2 = ccsu_pkg::qround(w_q[2], w_q[7], w_q[8],  w_q[13]);
      q3 = ccsu_pkg::qround(w_q[3], w_q[4], w_q[9],  w_q[14]);
      rnd_out[0] = q0[0]; rnd_out[5] = q0[1]; rnd_out[10] = q0[2]; rnd_out[15] = q0[3];
      rnd_out[1] = q1[0]; rnd_out[6] = q1[1]; rnd_out[11] = q1[2]; rnd_out[12] = q1[3];
      rnd_out[2] = q2[0]; rnd_out[7] = q2[1]; rnd_out[8]  = q2[2]; rnd_out[13] = q2[3];
      rnd_out[3] = q3[0]; rnd_out[4] = q3[1]; rnd_out[9]  = q3[2]; rnd_out[14] = q3[3];
    end
  end

  // final add of the input block
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ks_o[i] = w_q[i] + init_words[i];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    w_d     = w_q;
    unique case (state_q)
      CIdle: begin
        if (start_i) begin
          w_d     = ccsu_pkg::make_init(cfg_i, ctr_i);
          rnd_d   = '0;
          state_d = CRound;
        end
      end
      CRound: begin
        w_d   = rnd_out;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RndW'(RoundsEff - 1)) state_d = CFinal;
      end
      CFinal: state_d = CIdle;
      default: state_d = CIdle;
    endcase
  end

  assign stat_o.busy = (state_q != CIdle);
  assign stat_o.done = (state_q == CFinal);

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (start_i && state_q == CIdle) ctr_q <= ctr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

endmodule
`default_nettype wire

[sv/ccsu_back.sv]
`default_nettype none
module ccsu_back #(
  parameter int ROUND_COUNT = 20
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ccsu_pkg::cfg_t    cfg_i,
  input  wire logic              q_valid_i,
  input  wire ccsu_pkg::entry_t  head_i,
  output logic                   pop_o,
  ccsu_out_if.source             out_o
);

  localparam logic BIdle = 1'b0;
  localparam logic BWait = 1'b1;

  logic                  state_q;
  logic                  blk_ready_q;
  logic                  start;
  logic                  slot_free;
  logic                  out_valid_q;
  logic [31:0]           word_q;
  logic [2:0]            bytes_q;
  logic [31:0]           mask;
  ccsu_pkg::block_t      buf_q, ks;
  ccsu_pkg::core_stat_t  core_stat;

  ccsu_core #(.ROUND_COUNT(ROUND_COUNT)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .start_i(start),
    .ctr_i  (head_i.ctr),
    .stat_o (core_stat),
    .ks_o   (ks)
  );

  assign slot_free = ~out_valid_q | out_o.ready;

  // build a block before the head word that needs one, then emit
  assign start = (state_q == BIdle) & q_valid_i & head_i.build & ~blk_ready_q &
                 ~core_stat.busy;
  assign pop_o = (state_q == BIdle) & q_valid_i & (~head_i.build | blk_ready_q) &
                 slot_free;

  // byte mask from the valid byte count
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      mask[8 * b +: 8] = (3'(b) < head_i.nbytes) ? 8'hff : 8'h00;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_word  = word_q;
  assign out_o.result_bytes = bytes_q;

  // keystream buffer and output payload
  always_ff @(posedge clk_i) begin
    if (core_stat.done) buf_q <= ks;
    if (pop_o) begin
      word_q  <= (head_i.data ^ buf_q[head_i.pos]) & mask;
      bytes_q <= head_i.nbytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BIdle;
      blk_ready_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        BIdle: if (start) state_q <= BWait;
        BWait: if (core_stat.done) state_q <= BIdle;
        default: state_q <= BIdle;
      endcase
      if (core_stat.done) blk_ready_q <= 1'b1;
      else if (pop_o)     blk_ready_q <= 1'b0;
      if (pop_o)            out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[sv/chacha20_stream_cipher_unit.sv]
`default_nettype none
// ChaCha20 stream cipher, 64-bit nonce layout, one 32-bit word per transfer.
// in_i carries data_word, valid_bytes and message_start; out_o returns
// result_word (data XOR keystream, bytes past valid_bytes zeroed) and
// result_bytes. cfg_i writes the key words (indexes 0..3) and the nonce
// (index 4); other indexes are dropped. Write config only while idle.
// The first word of every 16, or any word with message_start set, builds a
// new keystream block: the core loads the input block, runs ROUND_COUNT
// rounds at one round per cycle (ROUND_COUNT rounded up to even) and adds
// the input block in its final state, then the word is emitted. Other words
// leave one per cycle from the buffered block while out_o is not stalled.
// A two-entry queue parts the input side from the core, so input is taken
// while a result waits. A stalled receiver holds the output register and
// then the queue fills and in_i.ready drops.
// Reset clears the key, nonce, block counter and word position.
module chacha20_stream_cipher_unit #(
  parameter int ROUND_COUNT = 20
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ccsu_in_if.sink    in_i,
  ccsu_out_if.source out_o,
  ccsu_cfg_if.sink   cfg_i
);

  ccsu_pkg::cfg_t   cfg_q;
  ccsu_pkg::entry_t entry, head;
  logic             push, pop, full, q_valid;

  // register file
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ccsu_pkg::RegKey01: cfg_q.key[0] <= cfg_i.data;
        ccsu_pkg::RegKey23: cfg_q.key[1] <= cfg_i.data;
        ccsu_pkg::RegKey45: cfg_q.key[2] <= cfg_i.data;
        ccsu_pkg::RegKey67: cfg_q.key[3] <= cfg_i.data;
        ccsu_pkg::RegNonce: cfg_q.nonce  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  ccsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .entry_o(entry)
  );

  ccsu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(q_valid),
    .head_o (head)
  );

  ccsu_back #(.ROUND_COUNT(ROUND_COUNT)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_valid_i(q_valid),
    .head_i   (head),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
`default_nettype wire

[test/chacha20_stream_cipher_unit_test.sv]
module chacha20_stream_cipher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RoundCount = 20;

  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;
  typedef enum int {CfgZeros, CfgOnes, CfgStripes, CfgRandom} cfg_kind_e;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
  } cipher_word_t;

  // keystream predictor plus the queue of cipher words still owed by the block
  class chacha_word_checker;
    logic [63:0]  key[4];
    logic [63:0]  nonce;
    logic [31:0]  counter;
    logic [3:0]   pos;
    logic [31:0]  keystream[16];
    logic [31:0]  work[16];
    cipher_word_t owed_q[$];
    int           errors;

    function new();
      foreach (key[k]) key[k] = '0;
      nonce   = '0;
      counter = '0;
      pos     = '0;
      errors  = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] value);
      case (idx)
        ccsu_pkg::RegKey01: key[0] = value;
        ccsu_pkg::RegKey23: key[1] = value;
        ccsu_pkg::RegKey45: key[2] = value;
        ccsu_pkg::RegKey67: key[3] = value;
        ccsu_pkg::RegNonce: nonce = value;
        default: ;  // unmapped index, dropped
      endcase
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void mix(int a, int b, int c, int d);
      work[a] = work[a] + work[b]; work[d] = rol(work[d] ^ work[a], 16);
      work[c] = work[c] + work[d]; work[b] = rol(work[b] ^ work[c], 12);
      work[a] = work[a] + work[b]; work[d] = rol(work[d] ^ work[a], 8);
      work[c] = work[c] + work[d]; work[b] = rol(work[b] ^ work[c], 7);
    endfunction

    // next 64-byte keystream block, counter advances and wraps
    function void next_block();
      logic [31:0] init[16];
      init[0] = ccsu_pkg::Sigma0;
      init[1] = ccsu_pkg::Sigma1;
      init[2] = ccsu_pkg::Sigma2;
      init[3] = ccsu_pkg::Sigma3;
      for (int k = 0; k < 4; k++) begin
        init[4 + 2 * k] = key[k][31:0];
        init[5 + 2 * k] = key[k][63:32];
      end
      init[12] = counter;
      init[13] = '0;
      init[14] = nonce[31:0];
      init[15] = nonce[63:32];
      work = init;
      // column and diagonal rounds in pairs, odd counts round up
      for (int r = 0; r < RoundCount; r += 2) begin
        mix(0, 4, 8, 12);
        mix(1, 5, 9, 13);
        mix(2, 6, 10, 14);
        mix(3, 7, 11, 15);
        mix(0, 5, 10, 15);
        mix(1, 6, 11, 12);
        mix(2, 7, 8, 13);
        mix(3, 4, 9, 14);
      end
      for (int k = 0; k < 16; k++) keystream[k] = work[k] + init[k];
      counter = counter + 32'd1;
    endfunction

    // accepted input word: work out the cipher word it owes
    function void take_word(logic [31:0] data, logic [2:0] nbytes, logic start);
      cipher_word_t owed;
      logic [31:0]  ks;
      logic [31:0]  mask;
      logic [2:0]   n;
      if (start) begin
        counter = '0;
        pos     = '0;
      end
      if (pos == 0) next_block();
      ks  = keystream[pos];
      pos = pos + 4'd1;
      n = (nbytes > ccsu_pkg::FullWordBytes) ? ccsu_pkg::FullWordBytes : nbytes;
      mask = (n == ccsu_pkg::FullWordBytes) ? 32'hffff_ffff :
             ((32'd1 << (8 * n)) - 32'd1);
      owed.word   = (data ^ ks) & mask;
      owed.nbytes = n;
      owed_q.push_back(owed);
    endfunction

    // accepted result word against the oldest owed one
    function void match_result(logic [31:0] word, logic [2:0] nbytes);
      cipher_word_t owed;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result word %08h bytes %0d", $time, word, nbytes);
        errors++;
        return;
      end
      owed = owed_q.pop_front();
      if (word !== owed.word) begin
        $display("%0t: result_word expected %08h actual %08h", $time, owed.word, word);
        errors++;
      end
      if (nbytes !== owed.nbytes) begin
        $display("%0t: result_bytes expected %0d actual %0d", $time, owed.nbytes, nbytes);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ccsu_in_if  in_bus();
  ccsu_out_if out_bus();
  ccsu_cfg_if cfg_bus();

  chacha_word_checker sb;
  idle_mode_e         traffic_mode = IdleNone;
  int                 items_sent = 0;

  chacha20_stream_cipher_unit #(
    .ROUND_COUNT(RoundCount)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result side: check each accepted word, stall at random
  always @(posedge clk_i) begin
    if (out_bus.valid && out_bus.ready) begin
      sb.match_result(out_bus.result_word, out_bus.result_bytes);
    end
    out_bus.ready <= !(((traffic_mode == IdleReceiver) && ($urandom_range(99) < 47)) ||
                       ((traffic_mode == IdleBoth) && ($urandom_range(99) < 24)));
  end

  // one input word, with random gaps ahead of it
  task automatic push_word(input logic [31:0] data, input logic [2:0] nbytes,
                           input logic start);
    while (((traffic_mode == IdleSender) && ($urandom_range(99) < 47)) ||
           ((traffic_mode == IdleBoth) && ($urandom_range(99) < 24))) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid         <= 1'b1;
    in_bus.data_word     <= data;
    in_bus.valid_bytes   <= nbytes;
    in_bus.message_start <= start;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.take_word(data, nbytes, start);
    items_sent++;
  endtask

  // hold off input until every owed word has come back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  // one register write, valid left high for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.set_reg(idx, value);
  endtask

  // key and nonce setting, then a write to an unmapped index
  task automatic load_config(input cfg_kind_e kind);
    logic [63:0] v[5];
    for (int k = 0; k < 5; k++) begin
      case (kind)
        CfgZeros:   v[k] = '0;
        CfgOnes:    v[k] = '1;
        CfgStripes: v[k] = k[0] ? 64'h5555_5555_5555_5555 : 64'haaaa_aaaa_aaaa_aaaa;
        default:    v[k] = {$urandom, $urandom};
      endcase
    end
    write_reg(ccsu_pkg::RegKey01, v[0]);
    write_reg(ccsu_pkg::RegKey23, v[1]);
    write_reg(ccsu_pkg::RegKey45, v[2]);
    write_reg(ccsu_pkg::RegKey67, v[3]);
    write_reg(ccsu_pkg::RegNonce, v[4]);
    write_reg(3'($urandom_range(7, ccsu_pkg::RegNonce + 1)), {$urandom, $urandom});
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int        quota;
    int        len;
    cfg_kind_e kind;
    sb = new();
    rst_ni               = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.data_word     = '0;
    in_bus.valid_bytes   = ccsu_pkg::FullWordBytes;
    in_bus.message_start = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = ccsu_pkg::RegKey01;
    cfg_bus.data         = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all-zero key, field extremes, odd byte counts, block crossing
    load_config(CfgZeros);
    push_word(32'h0000_0000, ccsu_pkg::FullWordBytes, 1'b1);
    push_word(32'hffff_ffff, ccsu_pkg::FullWordBytes, 1'b0);
    push_word(32'ha5a5_a5a5, 3'd3, 1'b0);
    push_word($urandom, 3'd2, 1'b0);
    push_word($urandom, 3'd1, 1'b0);
    // zero bytes still uses up a keystream word
    push_word($urandom, 3'd0, 1'b0);
    // counts above four saturate
    push_word($urandom, 3'd5, 1'b0);
    push_word($urandom, 3'd6, 1'b0);
    push_word($urandom, 3'd7, 1'b0);
    // runs past word 16 into the second block
    for (int k = 0; k < 9; k++) push_word($urandom, ccsu_pkg::FullWordBytes, 1'b0);
    // restart in the middle of a block
    push_word($urandom, ccsu_pkg::FullWordBytes, 1'b1);
    push_word($urandom, ccsu_pkg::FullWordBytes, 1'b0);
    drain_results();

    // random phases over key settings and idle patterns
    for (int p = 1; p <= 8; p++) begin
      case (p)
        1:       kind = CfgOnes;
        2:       kind = CfgStripes;
        5:       kind = CfgZeros;
        default: kind = CfgRandom;
      endcase
      load_config(kind);
      traffic_mode <= idle_mode_e'(p % 4);
      quota = items_sent + 175;
      while (items_sent < quota) begin
        if ($urandom_range(99) < 85) begin
          // well-formed message: start word, full words, tail of one to four bytes
          len = ($urandom_range(9) == 0) ? $urandom_range(70, 17) : $urandom_range(20, 1);
          for (int k = 0; k < len; k++) begin
            push_word($urandom,
                      (k == len - 1) ? 3'($urandom_range(4, 1)) : ccsu_pkg::FullWordBytes,
                      k == 0);
          end
        end else begin
          push_word($urandom, 3'($urandom), 1'($urandom));
        end
        if ($urandom_range(29) == 0) drain_results();
      end
      drain_results();
    end

    // quiet tail to catch stray results
    traffic_mode <= IdleNone;
    repeat (RoundCount + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
